### rtl/csd_pkg.sv
// ----------------------------------------------------------------------------
// csd_pkg - shared types and constants of the CTU split decision block
// Field widths, register map, back end states and the quadtree index helper.
// ----------------------------------------------------------------------------
package csd_pkg;

  localparam int UNIT_EDGE_DEF   = 64;
  localparam int DEPTH_LIMIT_DEF = 3;

  localparam int SAMPLE_W = 8;
  localparam int POS_W    = 6;
  localparam int SIZE_W   = 7;
  localparam int DEPTH_W  = 2;
  localparam int DC_W     = 8;
  localparam int COST_W   = 20;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // register index = paddr[2]
  localparam logic REG_MAX_SPLIT_DEPTH = 1'b0;
  localparam logic [DEPTH_W-1:0] MAX_SPLIT_DEPTH_RST = 2'd3;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_COST,
    BK_DRAIN,
    BK_CHECK,
    BK_READ,
    BK_OUT
  } back_state_e;

  typedef struct packed {
    logic [DC_W-1:0]   dc;
    logic [COST_W-1:0] cost;
  } node_t;

  typedef struct packed {
    logic cost_busy;
    logic tok_pop;
  } back_stat_t;

  typedef struct packed {
    logic               valid;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [SIZE_W-1:0]  size;
    logic [DEPTH_W-1:0] depth;
    logic [DC_W-1:0]    dc;
    logic [COST_W-1:0]  cost;
    logic               last;
  } leaf_t;

  // Raster index of a level-k node from finest-grid coordinates.
  function automatic logic [5:0] node_idx(input int k, input int dl,
                                          input logic [2:0] r, input logic [2:0] c);
    logic [5:0] rs;
    logic [5:0] cs;
    rs = {3'b000, r} >> (dl - k);
    cs = {3'b000, c} >> (dl - k);
    return (rs << k) | cs;
  endfunction

endpackage

### rtl/ctu_quadtree_split_decision.sv
// ----------------------------------------------------------------------------
// ctu_quadtree_split_decision - CTU quadtree split decision on DC/SAD cost
// Loads one tree unit, costs every quadtree block, emits the leaves in Z order.
// ----------------------------------------------------------------------------
//  channel   | signals                          | transaction
//  ----------+----------------------------------+------------------------------
//  sample in | start_i, busy_o, sample_value_i  | start_i & !busy_o at edge
//  leaf out  | leaf_valid_o, leaf_*_o, dc/cost  | one cycle strobe, no stall
//  config    | psel/penable/pwrite/paddr/pwdata | psel & penable & pwrite
//
//  Samples load at one per cycle while busy_o is low. The last sample
//  hands a token to the back end, which re-reads the sample store once,
//  one sample a cycle, holding busy_o high meanwhile. The walk then
//  checks, reads and emits each leaf, descending where split, overlapping
//  the load of the next unit. Reset clears counters, accumulators and flags;
//  the sample store and DC/cost RAMs need no clearing. Leaves cannot be held.
// ----------------------------------------------------------------------------
module ctu_quadtree_split_decision #(
  parameter int UNIT_EDGE   = csd_pkg::UNIT_EDGE_DEF,
  parameter int DEPTH_LIMIT = csd_pkg::DEPTH_LIMIT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [csd_pkg::SAMPLE_W-1:0]   sample_value_i,
  output logic                           leaf_valid_o,
  output logic [csd_pkg::POS_W-1:0]      leaf_row_o,
  output logic [csd_pkg::POS_W-1:0]      leaf_col_o,
  output logic [csd_pkg::SIZE_W-1:0]     leaf_size_o,
  output logic [csd_pkg::DEPTH_W-1:0]    leaf_depth_o,
  output logic [csd_pkg::DC_W-1:0]       dc_value_o,
  output logic [csd_pkg::COST_W-1:0]     leaf_cost_o,
  output logic                           last_leaf_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [csd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [csd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [csd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import csd_pkg::*;

  localparam int LOG2E = $clog2(UNIT_EDGE);
  localparam int AW    = 2 * LOG2E;

  logic [DEPTH_W-1:0] msd_q;
  logic [DEPTH_W-1:0] limit;
  logic               accept;

  logic                smp_we;
  logic [AW-1:0]       smp_waddr, smp_raddr;
  logic [SAMPLE_W-1:0] smp_wdata, smp_rdata;
  logic                unit_end;

  logic [DEPTH_LIMIT-1:0]          dc_row, dc_col;
  logic [DEPTH_LIMIT:0][DC_W-1:0]  dc_rd;

  logic               tok_valid;
  logic [DEPTH_W-1:0] tok_limit;
  back_stat_t         bstat;
  leaf_t              leaf;

  // config: single register at index 0, APB never waits
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_SPLIT_DEPTH) ? CFG_DATA_W'(msd_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msd_q <= MAX_SPLIT_DEPTH_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_MAX_SPLIT_DEPTH) begin
      msd_q <= pwdata[DEPTH_W-1:0];
    end
  end

  // the register is clamped to the built depth when the unit closes
  assign limit = (msd_q > DEPTH_W'(DEPTH_LIMIT)) ? DEPTH_W'(DEPTH_LIMIT) : msd_q;

  // front stalls while a loaded unit waits or is being re-read
  assign busy_o = tok_valid || bstat.cost_busy;
  assign accept = start_i && !busy_o;

  csd_front #(
    .UNIT_EDGE   (UNIT_EDGE),
    .DEPTH_LIMIT (DEPTH_LIMIT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .sample_i    (sample_value_i),
    .smp_we_o    (smp_we),
    .smp_waddr_o (smp_waddr),
    .smp_wdata_o (smp_wdata),
    .unit_end_o  (unit_end),
    .dc_row_i    (dc_row),
    .dc_col_i    (dc_col),
    .dc_o        (dc_rd)
  );

  csd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (UNIT_EDGE * UNIT_EDGE)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (smp_we),
    .waddr_i (smp_waddr),
    .wdata_i (smp_wdata),
    .raddr_i (smp_raddr),
    .rdata_o (smp_rdata)
  );

  csd_tokq u_tokq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (unit_end),
    .data_i  (limit),
    .pop_i   (bstat.tok_pop),
    .valid_o (tok_valid),
    .data_o  (tok_limit)
  );

  csd_back #(
    .UNIT_EDGE   (UNIT_EDGE),
    .DEPTH_LIMIT (DEPTH_LIMIT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_limit_i (tok_limit),
    .stat_o      (bstat),
    .smp_raddr_o (smp_raddr),
    .smp_rdata_i (smp_rdata),
    .dc_row_o    (dc_row),
    .dc_col_o    (dc_col),
    .dc_i        (dc_rd),
    .leaf_o      (leaf)
  );

  assign leaf_valid_o = leaf.valid;
  assign leaf_row_o   = leaf.row;
  assign leaf_col_o   = leaf.col;
  assign leaf_size_o  = leaf.size;
  assign leaf_depth_o = leaf.depth;
  assign dc_value_o   = leaf.dc;
  assign leaf_cost_o  = leaf.cost;
  assign last_leaf_o  = leaf.last;

endmodule

### rtl/csd_ram.sv
// ----------------------------------------------------------------------------
// csd_ram - generic simple dual port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module csd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/csd_tokq.sv
// ----------------------------------------------------------------------------
// csd_tokq - two entry unit token queue
// Carries the depth limit of each loaded unit from front end to back end.
// ----------------------------------------------------------------------------
module csd_tokq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [csd_pkg::DEPTH_W-1:0] data_i,
  input  logic                        pop_i,
  output logic                        valid_o,
  output logic [csd_pkg::DEPTH_W-1:0] data_o
);
  import csd_pkg::*;

  logic [DEPTH_W-1:0] slot_q [2];
  logic               wp_q, wp_d, rp_q, rp_d;
  logic [1:0]         cnt_q, cnt_d;

  always_comb begin
    wp_d  = wp_q ^ push_i;
    rp_d  = rp_q ^ pop_i;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot_q[rp_q];

endmodule

### rtl/csd_front.sv
// ----------------------------------------------------------------------------
// csd_front - sample loader and DC former
// Writes samples to the store and forms the DC of every quadtree block.
// ----------------------------------------------------------------------------
module csd_front #(
  parameter int UNIT_EDGE   = csd_pkg::UNIT_EDGE_DEF,
  parameter int DEPTH_LIMIT = csd_pkg::DEPTH_LIMIT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  logic [csd_pkg::SAMPLE_W-1:0]         sample_i,
  output logic                                 smp_we_o,
  output logic [2*$clog2(UNIT_EDGE)-1:0]       smp_waddr_o,
  output logic [csd_pkg::SAMPLE_W-1:0]         smp_wdata_o,
  output logic                                 unit_end_o,
  input  logic [DEPTH_LIMIT-1:0]               dc_row_i,
  input  logic [DEPTH_LIMIT-1:0]               dc_col_i,
  output logic [DEPTH_LIMIT:0][csd_pkg::DC_W-1:0] dc_o
);
  import csd_pkg::*;

  localparam int LOG2E = $clog2(UNIT_EDGE);
  localparam int AW    = 2 * LOG2E;
  localparam int DL    = DEPTH_LIMIT;
  localparam int NCOL  = 1 << DL;
  localparam int FIW   = 2 * DL;
  localparam int CIW   = (DL > 1) ? 2 * (DL - 1) : 1;
  localparam int NCRS  = 1 << CIW;
  localparam int SUM_W = SAMPLE_W + AW;

  logic [AW-1:0]    cnt_q, cnt_d;
  logic [LOG2E-1:0] row, col;
  logic [DL-1:0]    row_f, col_f;

  logic [SUM_W-1:0] acc_q [DL+1][NCOL];
  logic [SUM_W-1:0] acc_d [DL+1][NCOL];
  logic [DC_W-1:0]  dcc_q [DL][NCRS];
  logic [DC_W-1:0]  dcr_q [DL];
  logic [DC_W-1:0]  fine_rd;

  logic             done [DL+1];
  logic [DL-1:0]    ci   [DL+1];
  logic [SUM_W-1:0] sum  [DL+1];
  logic [DC_W-1:0]  dcv  [DL+1];
  logic [5:0]       idx  [DL+1];
  logic [5:0]       ridx [DL+1];
  logic [LOG2E-1:0] mask;

  assign row   = cnt_q[AW-1:LOG2E];
  assign col   = cnt_q[LOG2E-1:0];
  assign row_f = row[LOG2E-1 -: DL];
  assign col_f = col[LOG2E-1 -: DL];

  always_comb begin
    mask = '0;
    for (int k = 0; k <= DL; k++) begin
      mask    = LOG2E'((1 << (LOG2E - k)) - 1);
      done[k] = ((row & mask) == mask) && ((col & mask) == mask);
      ci[k]   = col_f >> (DL - k);
      sum[k]  = acc_q[k][ci[k]] + SUM_W'(sample_i);
      dcv[k]  = DC_W'(sum[k] >> (2 * (LOG2E - k)));
      idx[k]  = node_idx(k, DL, 3'(row_f), 3'(col_f));
      ridx[k] = node_idx(k, DL, 3'(dc_row_i), 3'(dc_col_i));
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    acc_d = acc_q;
    if (accept_i) begin
      cnt_d = cnt_q + AW'(1);
      for (int k = 0; k <= DL; k++) begin
        acc_d[k][ci[k]] = done[k] ? '0 : sum[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int k = 0; k <= DL; k++) begin
        for (int j = 0; j < NCOL; j++) begin
          acc_q[k][j] <= '0;
        end
      end
    end else begin
      cnt_q <= cnt_d;
      acc_q <= acc_d;
    end
  end

  // coarse level DCs in flops, read port registered to match the RAM
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DL; k++) begin
      if (accept_i && done[k]) begin
        dcc_q[k][idx[k][CIW-1:0]] <= dcv[k];
      end
      dcr_q[k] <= dcc_q[k][ridx[k][CIW-1:0]];
    end
  end

  csd_ram #(
    .WIDTH (DC_W),
    .DEPTH (1 << FIW)
  ) u_dc_ram (
    .clk_i   (clk_i),
    .we_i    (accept_i && done[DL]),
    .waddr_i (idx[DL][FIW-1:0]),
    .wdata_i (dcv[DL]),
    .raddr_i ({dc_row_i, dc_col_i}),
    .rdata_o (fine_rd)
  );

  always_comb begin
    for (int k = 0; k < DL; k++) begin
      dc_o[k] = dcr_q[k];
    end
    dc_o[DL] = fine_rd;
  end

  assign smp_we_o    = accept_i;
  assign smp_waddr_o = cnt_q;
  assign smp_wdata_o = sample_i;
  assign unit_end_o  = accept_i && (&cnt_q);

endmodule

### rtl/csd_back.sv
// ----------------------------------------------------------------------------
// csd_back - cost pass and quadtree walk
// Re-reads the unit, forms all level costs and split flags, emits leaves.
// ----------------------------------------------------------------------------
module csd_back #(
  parameter int UNIT_EDGE   = csd_pkg::UNIT_EDGE_DEF,
  parameter int DEPTH_LIMIT = csd_pkg::DEPTH_LIMIT_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    tok_valid_i,
  input  logic [csd_pkg::DEPTH_W-1:0]             tok_limit_i,
  output csd_pkg::back_stat_t                     stat_o,
  output logic [2*$clog2(UNIT_EDGE)-1:0]          smp_raddr_o,
  input  logic [csd_pkg::SAMPLE_W-1:0]            smp_rdata_i,
  output logic [DEPTH_LIMIT-1:0]                  dc_row_o,
  output logic [DEPTH_LIMIT-1:0]                  dc_col_o,
  input  logic [DEPTH_LIMIT:0][csd_pkg::DC_W-1:0] dc_i,
  output csd_pkg::leaf_t                          leaf_o
);
  import csd_pkg::*;

  localparam int LOG2E = $clog2(UNIT_EDGE);
  localparam int AW    = 2 * LOG2E;
  localparam int DL    = DEPTH_LIMIT;
  localparam int NCOL  = 1 << DL;
  localparam int FIW   = 2 * DL;
  localparam int ZW    = 2 * DL;
  localparam int CIW   = (DL > 1) ? 2 * (DL - 1) : 1;
  localparam int NCRS  = 1 << CIW;

  back_state_e state_q, state_d;

  logic [DEPTH_W-1:0] lim_q;
  logic [AW-1:0]      ra_q, ra1_q;
  logic               v1_q;
  logic [ZW-1:0]      z_q;
  logic [DEPTH_W-1:0] d_q;
  node_t              leaf_nd_q;

  logic [COST_W-1:0] cacc_q [DL+1][NCOL];
  logic [COST_W-1:0] cacc_d [DL+1][NCOL];
  logic [COST_W-1:0] csum_q [DL][NCOL];
  logic [COST_W-1:0] csum_d [DL][NCOL];
  node_t             ncr_q  [DL][NCRS];
  logic              split_q [DL][NCRS];

  // cost pass, stage one
  logic [LOG2E-1:0]  row1, col1, mask;
  logic [DL-1:0]     row_f, col_f;
  logic              done [DL+1];
  logic [DL-1:0]     ci   [DL+1];
  logic [DC_W-1:0]   diff [DL+1];
  logic [COST_W-1:0] cst  [DL+1];
  logic [COST_W-1:0] psum [DL];
  logic [5:0]        idx  [DL+1];
  node_t             fine_rd;

  // walk
  logic [DL-1:0]      row_w, col_w;
  logic [5:0]         widx [DL+1];
  logic               sp, descend;
  logic [ZW:0]        zn;
  logic               ovf;
  logic [DEPTH_W-1:0] dn;
  node_t              coarse_sel, leaf_nd;
  logic [LOG2E-1:0]   rfull, cfull;

  assign row1  = ra1_q[AW-1:LOG2E];
  assign col1  = ra1_q[LOG2E-1:0];
  assign row_f = row1[LOG2E-1 -: DL];
  assign col_f = col1[LOG2E-1 -: DL];

  always_comb begin
    mask = '0;
    for (int k = 0; k <= DL; k++) begin
      mask    = LOG2E'((1 << (LOG2E - k)) - 1);
      done[k] = ((row1 & mask) == mask) && ((col1 & mask) == mask);
      ci[k]   = col_f >> (DL - k);
      diff[k] = (smp_rdata_i >= dc_i[k]) ? (smp_rdata_i - dc_i[k]) : (dc_i[k] - smp_rdata_i);
      cst[k]  = cacc_q[k][ci[k]] + COST_W'(diff[k]);
      idx[k]  = node_idx(k, DL, 3'(row_f), 3'(col_f));
    end
    for (int k = 0; k < DL; k++) begin
      psum[k] = csum_q[k][ci[k]] + cst[k+1];
    end
  end

  always_comb begin
    cacc_d = cacc_q;
    csum_d = csum_q;
    if (v1_q) begin
      for (int k = 0; k <= DL; k++) begin
        cacc_d[k][ci[k]] = done[k] ? '0 : cst[k];
      end
      for (int k = 0; k < DL; k++) begin
        if (done[k+1]) begin
          csum_d[k][ci[k]] = done[k] ? '0 : psum[k];
        end
      end
    end
  end

  // walk: z holds the quadrant digits, top level in the upper bits
  always_comb begin
    for (int j = 0; j < DL; j++) begin
      row_w[j] = z_q[2*j+1];
      col_w[j] = z_q[2*j];
    end
    for (int k = 0; k <= DL; k++) begin
      widx[k] = node_idx(k, DL, 3'(row_w), 3'(col_w));
    end
    sp         = 1'b0;
    coarse_sel = ncr_q[0][widx[0][CIW-1:0]];
    for (int k = 0; k < DL; k++) begin
      if (d_q == DEPTH_W'(k)) begin
        sp         = split_q[k][widx[k][CIW-1:0]];
        coarse_sel = ncr_q[k][widx[k][CIW-1:0]];
      end
    end
    descend = (d_q < lim_q) && sp;
    zn  = {1'b0, z_q} + ((ZW+1)'(1) << (2 * (DL - int'(d_q))));
    ovf = zn[ZW];
    dn  = d_q;
    for (int j = DL; j >= 1; j--) begin
      if (dn == DEPTH_W'(j) && zn[2*(DL-j) +: 2] == 2'b00) begin
        dn = DEPTH_W'(j - 1);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:  if (tok_valid_i) state_d = BK_COST;
      BK_COST:  if (&ra_q) state_d = BK_DRAIN;
      BK_DRAIN: state_d = BK_CHECK;
      BK_CHECK: if (!descend) state_d = BK_READ;
      BK_READ:  state_d = BK_OUT;
      BK_OUT:   state_d = ovf ? BK_IDLE : BK_CHECK;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      v1_q    <= 1'b0;
      for (int k = 0; k <= DL; k++) begin
        for (int j = 0; j < NCOL; j++) begin
          cacc_q[k][j] <= '0;
        end
      end
      for (int k = 0; k < DL; k++) begin
        for (int j = 0; j < NCOL; j++) begin
          csum_q[k][j] <= '0;
        end
        for (int j = 0; j < NCRS; j++) begin
          split_q[k][j] <= 1'b0;
        end
      end
    end else begin
      state_q <= state_d;
      v1_q    <= (state_q == BK_COST);
      cacc_q  <= cacc_d;
      csum_q  <= csum_d;
      for (int k = 0; k < DL; k++) begin
        if (v1_q && done[k]) begin
          split_q[k][idx[k][CIW-1:0]] <= (cst[k] > psum[k]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ra1_q <= ra_q;
    for (int k = 0; k < DL; k++) begin
      if (v1_q && done[k]) begin
        ncr_q[k][idx[k][CIW-1:0]] <= '{dc: dc_i[k], cost: cst[k]};
      end
    end
    unique case (state_q)
      BK_IDLE: begin
        lim_q <= tok_limit_i;
        ra_q  <= '0;
      end
      BK_COST:  ra_q <= ra_q + AW'(1);
      BK_DRAIN: begin
        z_q <= '0;
        d_q <= '0;
      end
      BK_CHECK: if (descend) d_q <= d_q + DEPTH_W'(1);
      BK_READ:  leaf_nd_q <= coarse_sel;
      BK_OUT: begin
        z_q <= zn[ZW-1:0];
        d_q <= dn;
      end
      default: ;
    endcase
  end

  csd_ram #(
    .WIDTH ($bits(node_t)),
    .DEPTH (1 << FIW)
  ) u_cost_ram (
    .clk_i   (clk_i),
    .we_i    (v1_q && done[DL]),
    .waddr_i (idx[DL][FIW-1:0]),
    .wdata_i ({dc_i[DL], cst[DL]}),
    .raddr_i ({row_w, col_w}),
    .rdata_o (fine_rd)
  );

  assign smp_raddr_o = ra_q;
  assign dc_row_o    = ra_q[AW-1 -: DL];
  assign dc_col_o    = ra_q[LOG2E-1 -: DL];

  always_comb begin
    stat_o.cost_busy = (state_q == BK_COST) || (state_q == BK_DRAIN);
    stat_o.tok_pop   = (state_q == BK_IDLE) && tok_valid_i;
    leaf_nd      = (d_q == DEPTH_W'(DL)) ? fine_rd : leaf_nd_q;
    rfull        = {row_w, {(LOG2E-DL){1'b0}}};
    cfull        = {col_w, {(LOG2E-DL){1'b0}}};
    leaf_o.valid = (state_q == BK_OUT);
    leaf_o.row   = POS_W'(rfull);
    leaf_o.col   = POS_W'(cfull);
    leaf_o.size  = SIZE_W'(UNIT_EDGE) >> d_q;
    leaf_o.depth = d_q;
    leaf_o.dc    = leaf_nd.dc;
    leaf_o.cost  = leaf_nd.cost;
    leaf_o.last  = ovf;
  end

endmodule

### rtl/csd_checker.sv
// ----------------------------------------------------------------------------
// csd_checker - port level checks of the split decision block
// Leaf strobe spacing and leaf geometry, bound to the top level.
// ----------------------------------------------------------------------------
module csd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        leaf_valid_i,
  input logic [csd_pkg::POS_W-1:0]   leaf_row_i,
  input logic [csd_pkg::POS_W-1:0]   leaf_col_i,
  input logic [csd_pkg::SIZE_W-1:0]  leaf_size_i
);
  import csd_pkg::*;

  // the walk never puts two leaf strobes back to back
  a_leaf_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    leaf_valid_i |=> !leaf_valid_i)
    else $error("leaf strobes on consecutive cycles");

  a_leaf_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    leaf_valid_i |-> $onehot(leaf_size_i))
    else $error("leaf size not a power of two");

  // a leaf sits on a multiple of its own size
  a_leaf_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    leaf_valid_i |-> ((SIZE_W'(leaf_row_i) & (leaf_size_i - SIZE_W'(1))) == '0 &&
                      (SIZE_W'(leaf_col_i) & (leaf_size_i - SIZE_W'(1))) == '0))
    else $error("leaf not aligned to its size");

endmodule

bind ctu_quadtree_split_decision csd_checker u_csd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .leaf_valid_i (leaf_valid_o),
  .leaf_row_i   (leaf_row_o),
  .leaf_col_i   (leaf_col_o),
  .leaf_size_i  (leaf_size_o)
);

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench of the CTU quadtree split decision block
// Streams whole 64x64 tree units of samples into the block, predicts every
// leaf of the greedy DC/SAD quadtree decision and checks each leaf strobe in
// order. It covers flat units, every depth setting and randomised content.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import csd_pkg::*;

  localparam int EDGE    = UNIT_EDGE_DEF;
  localparam int SAMPLES = EDGE * EDGE;
  localparam int DLIMIT  = DEPTH_LIMIT_DEF;

  // register indexes (byte address = 4 * index)
  localparam int unsigned IDX_MAX_DEPTH = 0;
  localparam int unsigned IDX_UNUSED    = 1;

  typedef enum int {PAT_FLAT, PAT_BLOCKY, PAT_NOISE} pattern_e;

  typedef struct {
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [SIZE_W-1:0]  size;
    logic [DEPTH_W-1:0] depth;
    logic [DC_W-1:0]    dc;
    logic [COST_W-1:0]  cost;
    logic               last;
  } leaf_rec_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [SAMPLE_W-1:0]   sample_value_i;
  logic                  leaf_valid_o;
  logic [POS_W-1:0]      leaf_row_o;
  logic [POS_W-1:0]      leaf_col_o;
  logic [SIZE_W-1:0]     leaf_size_o;
  logic [DEPTH_W-1:0]    leaf_depth_o;
  logic [DC_W-1:0]       dc_value_o;
  logic [COST_W-1:0]     leaf_cost_o;
  logic                  last_leaf_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // predictor state
  logic [SAMPLE_W-1:0] unit_store [SAMPLES];
  int unsigned         sample_count;
  logic [DEPTH_W-1:0]  depth_reg;

  logic [SAMPLE_W-1:0] unit_buf [SAMPLES]; // stimulus of the next unit
  leaf_rec_t           expected_leaves[$];
  int unsigned         n_errors;
  int unsigned         n_leaves;
  int unsigned         n_units;
  bit                  gaps_on;

  ctu_quadtree_split_decision i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .sample_value_i,
    .leaf_valid_o, .leaf_row_o, .leaf_col_o, .leaf_size_o, .leaf_depth_o,
    .dc_value_o, .leaf_cost_o, .last_leaf_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog: well above a dozen units with worst-case gaps and back end passes
  initial begin
    #30ms;
    $display("timeout at %0t", $time);
    $display("[ctu_quadtree_split_decision] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // SAD of one square block against its truncated mean
  function automatic int unsigned block_sad(int r, int c, int sz, output int unsigned dc);
    int unsigned sum;
    int unsigned cost;
    int unsigned s;
    sum = 0;
    cost = 0;
    for (int i = 0; i < sz; i++)
      for (int j = 0; j < sz; j++)
        sum += unit_store[(r + i) * EDGE + c + j];
    dc = sum / (sz * sz);
    for (int i = 0; i < sz; i++)
      for (int j = 0; j < sz; j++) begin
        s = unit_store[(r + i) * EDGE + c + j];
        cost += (s >= dc) ? s - dc : dc - s;
      end
    return cost;
  endfunction

  // greedy top-down decision; leaves are queued in Z order
  function automatic void decide_node(int r, int c, int sz, int depth, int limit);
    int unsigned dc;
    int unsigned cost;
    int unsigned cdc;
    int unsigned child_sum;
    int          h;
    leaf_rec_t   lf;
    cost = block_sad(r, c, sz, dc);
    if (depth < limit && sz >= 2) begin
      h = sz / 2;
      child_sum = block_sad(r, c, h, cdc) + block_sad(r, c + h, h, cdc)
                + block_sad(r + h, c, h, cdc) + block_sad(r + h, c + h, h, cdc);
      // a tie keeps the parent whole
      if (cost > child_sum) begin
        decide_node(r, c, h, depth + 1, limit);
        decide_node(r, c + h, h, depth + 1, limit);
        decide_node(r + h, c, h, depth + 1, limit);
        decide_node(r + h, c + h, h, depth + 1, limit);
        return;
      end
    end
    lf.row   = r[POS_W-1:0];
    lf.col   = c[POS_W-1:0];
    lf.size  = sz[SIZE_W-1:0];
    lf.depth = depth[DEPTH_W-1:0];
    lf.dc    = dc[DC_W-1:0];
    lf.cost  = cost[COST_W-1:0];
    lf.last  = 1'b0;
    expected_leaves.push_back(lf);
  endfunction

  // one accepted sample; the last of a unit produces the leaf list
  function automatic void predict_sample(logic [SAMPLE_W-1:0] v);
    int limit;
    unit_store[sample_count] = v;
    sample_count++;
    if (sample_count < SAMPLES) return;
    sample_count = 0;
    n_units++;
    limit = (depth_reg > DLIMIT) ? DLIMIT : depth_reg;
    decide_node(0, 0, EDGE, 0, limit);
    expected_leaves[expected_leaves.size() - 1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Leaf checker: no back pressure, every strobe is a transaction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    leaf_rec_t ex;
    if (rst_ni && leaf_valid_o) begin
      n_leaves++;
      if (expected_leaves.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected leaf row %0d col %0d", $time, leaf_row_o, leaf_col_o);
      end else begin
        ex = expected_leaves.pop_front();
        if (leaf_row_o !== ex.row || leaf_col_o !== ex.col || leaf_size_o !== ex.size ||
            leaf_depth_o !== ex.depth || dc_value_o !== ex.dc ||
            leaf_cost_o !== ex.cost || last_leaf_o !== ex.last) begin
          n_errors++;
          $display("%0t: leaf mismatch exp r%0d c%0d s%0d d%0d dc%0d cost%0d last%0d",
                   $time, ex.row, ex.col, ex.size, ex.depth, ex.dc, ex.cost, ex.last);
          $display("%0t:               got r%0d c%0d s%0d d%0d dc%0d cost%0d last%0d",
                   $time, leaf_row_o, leaf_col_o, leaf_size_o, leaf_depth_o,
                   dc_value_o, leaf_cost_o, last_leaf_o);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // one sample transaction, with an optional random gap in front
  task automatic send_sample(logic [SAMPLE_W-1:0] v);
    if (gaps_on && $urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk_i);
        start_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    start_i        <= 1'b1;
    sample_value_i <= v;
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    predict_sample(v);
  endtask

  // drop start and wait until every queued leaf has shown up
  task automatic drain_leaves();
    @(negedge clk_i);
    start_i <= 1'b0;
    wait (expected_leaves.size() == 0);
  endtask

  // idle point for register access: leaves drained and back end settled
  task automatic settle();
    drain_leaves();
    repeat (300) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic cfg_write(int unsigned idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(4 * idx);
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == IDX_MAX_DEPTH) depth_reg = val[DEPTH_W-1:0];
  endtask

  task automatic cfg_check_depth();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_ADDR_W'(4 * IDX_MAX_DEPTH);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[DEPTH_W-1:0] !== depth_reg) begin
      n_errors++;
      $display("%0t: depth register read exp %0d got %0d", $time, depth_reg,
               prdata[DEPTH_W-1:0]);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // build one unit: flat, blocky with noise at a given grain, or pure noise
  task automatic fill_unit(pattern_e pat, int flat_val, int grain, int noise);
    int base [64];
    int v;
    foreach (base[k]) base[k] = $urandom_range(0, 255);
    for (int r = 0; r < EDGE; r++)
      for (int c = 0; c < EDGE; c++) begin
        case (pat)
          PAT_FLAT:   v = flat_val;
          PAT_NOISE:  v = $urandom_range(0, 255);
          default: begin
            v = base[(r / grain) * 8 + (c / grain)];
            v += $urandom_range(0, 2 * noise) - noise;
            if (v < 0)   v = 0;
            if (v > 255) v = 255;
          end
        endcase
        unit_buf[r * EDGE + c] = v[SAMPLE_W-1:0];
      end
  endtask

  task automatic send_unit();
    for (int k = 0; k < SAMPLES; k++) send_sample(unit_buf[k]);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // flat units: every cost ties at zero, so nothing splits
  task automatic test_flat_units();
    cfg_check_depth();
    fill_unit(PAT_FLAT, 0, 8, 0);
    send_unit();
    fill_unit(PAT_FLAT, 255, 8, 0);
    send_unit();
    settle();
  endtask

  // each depth setting on blocky content, extremes included
  task automatic test_depth_settings();
    int order [4] = '{0, 3, 1, 2};
    foreach (order[k]) begin
      cfg_write(IDX_MAX_DEPTH, order[k]);
      // writes to the unused register index must leave the depth alone
      if (k == 1) cfg_write(IDX_UNUSED, 32'h0);
      cfg_check_depth();
      fill_unit(PAT_BLOCKY, 0, 8, 1);
      send_unit();
      settle();
    end
  endtask

  // random content and grain, random gaps, two mid-run drains
  task automatic test_random_units();
    int grains [3] = '{8, 16, 32};
    gaps_on = 1'b1;
    for (int u = 0; u < 5; u++) begin
      if (u == 4) gaps_on = 1'b0; // final unit back to back
      if (u == 2) drain_leaves();
      if (u == 3) begin
        settle();
        cfg_write(IDX_MAX_DEPTH, $urandom_range(0, 3));
      end
      if ($urandom_range(0, 3) == 0) fill_unit(PAT_NOISE, 0, 8, 0);
      else fill_unit(PAT_BLOCKY, 0, grains[$urandom_range(0, 2)], $urandom_range(0, 20));
      send_unit();
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    sample_value_i = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    sample_count   = 0;
    depth_reg      = MAX_SPLIT_DEPTH_RST;
    n_errors       = 0;
    n_leaves       = 0;
    n_units        = 0;
    gaps_on        = 1'b0;
    foreach (unit_store[k]) unit_store[k] = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_flat_units();
    test_depth_settings();
    test_random_units();

    drain_leaves();
    repeat (300) @(posedge clk_i);
    $display("covered %0d tree units and %0d leaves over depth settings 0..3,",
             n_units, n_leaves);
    $display("flat, blocky and noise content, with and without sender gaps");
    if (n_errors == 0) begin
      $display("[ctu_quadtree_split_decision] OK");
    end else begin
      $display("[ctu_quadtree_split_decision] ERROR");
    end
    $finish;
  end

endmodule
